@@ hw/rtl/prcc_pkg.sv @@
// Shared types and constants for the packet reorder and checksum check block.
package prcc_pkg;

	localparam int MAX_PACKETS_DEF = 64;
	localparam int PAYLOAD_MAX     = 9;
	localparam int QUEUE_DEPTH     = 4;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 2;

	localparam int SUM_W      = 18;
	localparam int BYTE_SUM_W = 12;

	// One stored packet: key is message id over packet id.
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] payload_low;
		logic [7:0]  payload_high;
		logic [3:0]  length;
		logic        ok;
	} pkt_t;

	typedef struct packed {
		pkt_t pkt;
		logic last;
	} qent_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} sort_st_t;

endpackage

@@ hw/rtl/prcc_front.sv @@
// Front stage: accept a packet beat, sum its bytes, ids and length, flag the check result.
module prcc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [prcc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	output logic                             push,
	output prcc_pkg::qent_t                  push_ent,
	input  logic                             full
);

	logic        v_s1;
	logic [15:0] mid_s1;
	logic [15:0] pid_s1;
	logic [3:0]  len_s1;
	logic [63:0] lo_s1;
	logic [7:0]  hi_s1;
	logic [17:0] code_s1;
	logic        last_s1;
	logic [prcc_pkg::BYTE_SUM_W-1:0] bsum_s1;

	logic [3:0]  in_len;
	logic [63:0] in_lo;
	logic [7:0]  in_hi;
	logic [prcc_pkg::BYTE_SUM_W-1:0] bsum;
	logic [prcc_pkg::SUM_W-1:0]      total;

	assign in_len = s_tdata[35:32];
	assign in_lo  = s_tdata[99:36];
	assign in_hi  = s_tdata[107:100];

	// count only bytes below both the length and the payload limit
	always_comb begin
		bsum = '0;
		for (int i = 0; i < 8; i++) begin
			if (in_len > 4'(i) && i < prcc_pkg::PAYLOAD_MAX)
				bsum = bsum + prcc_pkg::BYTE_SUM_W'(in_lo[8*i +: 8]);
		end
		if (in_len > 4'd8 && prcc_pkg::PAYLOAD_MAX > 8)
			bsum = bsum + prcc_pkg::BYTE_SUM_W'(in_hi);
	end

	assign s_tready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mid_s1  <= s_tdata[15:0];
			pid_s1  <= s_tdata[31:16];
			len_s1  <= in_len;
			lo_s1   <= in_lo;
			hi_s1   <= in_hi;
			code_s1 <= s_tdata[125:108];
			last_s1 <= s_tlast;
			bsum_s1 <= bsum;
		end
	end

	assign total = prcc_pkg::SUM_W'(bsum_s1) + prcc_pkg::SUM_W'(mid_s1)
		+ prcc_pkg::SUM_W'(pid_s1) + prcc_pkg::SUM_W'(len_s1);

	always_comb begin
		push_ent.pkt.key          = {mid_s1, pid_s1};
		push_ent.pkt.payload_low  = lo_s1;
		push_ent.pkt.payload_high = hi_s1;
		push_ent.pkt.length       = len_s1;
		push_ent.pkt.ok           = (total == code_s1);
		push_ent.last             = last_s1;
	end

endmodule

@@ hw/rtl/prcc_queue.sv @@
// Short queue between the checksum front and the sorting back end.
module prcc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  prcc_pkg::qent_t push_ent,
	output logic            full,
	input  logic            pop,
	output prcc_pkg::qent_t pop_ent,
	output logic            pop_valid
);

	localparam int PW = $clog2(prcc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(prcc_pkg::QUEUE_DEPTH + 1);

	prcc_pkg::qent_t ent_q [prcc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_pop;

	assign full      = (cnt_q == CW'(prcc_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_ent   = ent_q[rd_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PW'(1);
			if (do_pop)
				rd_q <= rd_q + PW'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_ent;
	end

endmodule

@@ hw/rtl/prcc_sorter.sv @@
// Back end: insertion chain of packet cells that sorts on load and shifts out on emit.
module prcc_sorter #(
	parameter int MAX_PACKETS = prcc_pkg::MAX_PACKETS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  prcc_pkg::qent_t in_ent,
	output logic            in_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output prcc_pkg::pkt_t  out_pkt,
	output logic            out_new,
	output logic            out_last
);

	localparam int CW = $clog2(MAX_PACKETS + 1);

	prcc_pkg::sort_st_t state_q, state_d;
	prcc_pkg::pkt_t     cell_q [MAX_PACKETS];
	logic [CW-1:0]      count_q;
	logic               first_q;
	logic [15:0]        prev_mid_q;
	logic [MAX_PACKETS-1:0] gt;
	logic               ins;
	logic               shift;

	// a cell moves aside when it is empty or holds a strictly greater key
	always_comb begin
		for (int i = 0; i < MAX_PACKETS; i++)
			gt[i] = (CW'(i) >= count_q) || (cell_q[i].key > in_ent.pkt.key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prcc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_pop  = 1'b0;
		shift   = 1'b0;
		unique case (state_q)
			prcc_pkg::ST_LOAD: begin
				in_pop = in_valid;
				if (in_valid && in_ent.last)
					state_d = prcc_pkg::ST_EMIT;
			end
			prcc_pkg::ST_EMIT: begin
				shift = out_ready;
				if (out_ready && count_q == CW'(1))
					state_d = prcc_pkg::ST_LOAD;
			end
			default: state_d = prcc_pkg::ST_LOAD;
		endcase
	end

	// drop the packet when every cell is taken
	assign ins = in_pop && (count_q < CW'(MAX_PACKETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			first_q    <= 1'b1;
			prev_mid_q <= '0;
		end else begin
			if (ins)
				count_q <= count_q + CW'(1);
			else if (shift)
				count_q <= count_q - CW'(1);
			if (in_pop && in_ent.last)
				first_q <= 1'b1;
			else if (shift)
				first_q <= 1'b0;
			if (shift)
				prev_mid_q <= cell_q[0].key[31:16];
		end
	end

	for (genvar i = 0; i < MAX_PACKETS; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (ins) begin
					if (gt[0])
						cell_q[0] <= in_ent.pkt;
				end else if (shift) begin
					cell_q[0] <= cell_q[1];
				end
			end
		end else if (i == MAX_PACKETS - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (ins && gt[i])
					cell_q[i] <= gt[i-1] ? cell_q[i-1] : in_ent.pkt;
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (ins) begin
					if (gt[i])
						cell_q[i] <= gt[i-1] ? cell_q[i-1] : in_ent.pkt;
				end else if (shift) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	assign out_valid = (state_q == prcc_pkg::ST_EMIT);
	assign out_pkt   = cell_q[0];
	assign out_new   = !first_q && (cell_q[0].key[31:16] != prev_mid_q);
	assign out_last  = (count_q == CW'(1));

endmodule

@@ hw/rtl/packet_reorder_checksum_check_core.sv @@
// Top level of the packet reorder and additive checksum check block.
// Packets enter one beat per cycle while s_tready is high: a front stage
// checks the additive checksum (payload bytes up to the length, both ids and
// the length against the check code), a four-entry queue follows, and an
// insertion chain of MAX_PACKETS cells places each packet in message id,
// packet id order, equal keys in arrival order. A beat with tlast closes the
// set; the chain then shifts out n packets in n beats, one per cycle while
// m_tready is high, and takes no new packet until the last one has left, so
// input stalls once the queue fills. Packets arriving with MAX_PACKETS already
// held are dropped.
module packet_reorder_checksum_check_core #(
	parameter int MAX_PACKETS = prcc_pkg::MAX_PACKETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// message_id, packet_id, payload_length, payload_low, payload_high, check_code
	input  logic [prcc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// message_id_out, packet_id_out, length_out, payload_low_out, payload_high_out
	output logic [prcc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// checksum_ok, new_message
	output logic [prcc_pkg::OUT_USER_W-1:0]   m_tuser,
	output logic                              m_tlast
);

	logic            push;
	logic            full;
	logic            pop;
	logic            pop_valid;
	prcc_pkg::qent_t push_ent;
	prcc_pkg::qent_t pop_ent;
	prcc_pkg::pkt_t  out_pkt;
	logic            out_new;

	prcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_ent (push_ent),
		.full     (full)
	);

	prcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (full),
		.pop       (pop),
		.pop_ent   (pop_ent),
		.pop_valid (pop_valid)
	);

	prcc_sorter #(
		.MAX_PACKETS (MAX_PACKETS)
	) u_sorter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_valid),
		.in_ent    (pop_ent),
		.in_pop    (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pkt   (out_pkt),
		.out_new   (out_new),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0, out_pkt.payload_high, out_pkt.payload_low, out_pkt.length,
		out_pkt.key[15:0], out_pkt.key[31:16]};
	assign m_tuser = {out_new, out_pkt.ok};

endmodule

@@ hw/rtl/prcc_checker.sv @@
// Port-level checks on the sorted output stream, bound to the top level.
module prcc_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [prcc_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [prcc_pkg::OUT_USER_W-1:0] m_tuser,
	input logic                            m_tlast
);

	logic        first_q;
	logic [31:0] prev_key_q;
	logic [31:0] key;

	assign key = {m_tdata[15:0], m_tdata[31:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			prev_key_q <= '0;
		end else if (m_tvalid && m_tready) begin
			first_q    <= m_tlast;
			prev_key_q <= key;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_first_not_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> !m_tuser[1])
		else $error("first beat of a set flagged as new message");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !first_q |-> key >= prev_key_q)
		else $error("output beats out of key order");

	a_new_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !first_q |-> m_tuser[1] == (key[31:16] != prev_key_q[31:16]))
		else $error("new message flag does not match message id change");

endmodule

bind packet_reorder_checksum_check_core prcc_port_checks u_prcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
